>>> design/lmfs_pkg.sv
`timescale 1ns / 1ps

package lmfs_pkg;

  typedef enum logic [2:0] {
    REQ_PIXEL     = 3'd0,
    REQ_FILL      = 3'd1,
    REQ_REFRESH   = 3'd2,
    REQ_INTENSITY = 3'd3,
    REQ_BROADCAST = 3'd4
  } req_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_SCAN_RD,
    ST_SCAN_LD,
    ST_SCAN_OUT,
    ST_BCAST
  } state_t;

  localparam logic [3:0] REG_INTENSITY = 4'hA;
  localparam logic [7:0] INTENSITY_MAX = 8'd15;
  localparam logic [7:0] BYTE_ONES     = 8'hFF;
  localparam int         ROWS          = 8;
  localparam logic [2:0] LAST_ROW      = 3'd7;

endpackage

>>> design/lmfs_if.sv
`timescale 1ns / 1ps

interface lmfs_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic               color;
  logic [3:0]         reg_sel;
  logic [7:0]         value;

  modport source (output valid, req_type, pos_x, pos_y, color, reg_sel, value, input ready);
  modport sink (input valid, req_type, pos_x, pos_y, color, reg_sel, value, output ready);
endinterface

interface lmfs_word_if;
  logic       valid;
  logic       ready;
  logic [3:0] out_reg;
  logic [7:0] out_data;
  logic       frame_end;
  logic       last;

  modport source (output valid, out_reg, out_data, frame_end, last, input ready);
  modport sink (input valid, out_reg, out_data, frame_end, last, output ready);
endinterface

>>> design/lmfs_ram.sv
`timescale 1ns / 1ps

module lmfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/led_matrix_frame_scanner.sv
`timescale 1ns / 1ps

// Frame store for a grid of H_DISPLAYS x V_DISPLAYS chained 8x8 LED drivers, one bit per
// pixel, kept in a single RAM of row bytes (module m, row r at address m*8 + r). One request
// is handled at a time. A pixel request is a read-modify-write of one byte; a pixel off the
// panel is taken and dropped. A fill request sweeps the whole RAM, one byte a cycle: 8 times
// the module count rounded up to a power of two (at least 2) bytes. After reset the same
// sweep clears the store, and no request is taken during the sweep. A refresh streams
// 8*H_DISPLAYS*V_DISPLAYS words, each through RAM read, output load and output beat, the
// next RAM read starting only once the beat is taken. Intensity and broadcast requests
// send one word per cycle while the sink is ready. Unused request codes are taken and do
// nothing.
module led_matrix_frame_scanner
  import lmfs_pkg::*;
#(
  parameter int H_DISPLAYS = 4,
  parameter int V_DISPLAYS = 2
) (
  input  logic        clk,
  input  logic        rst,
  lmfs_req_if.sink    req,
  lmfs_word_if.source word
);

  localparam int NUM_MODULES = H_DISPLAYS * V_DISPLAYS;
  localparam int MW          = (NUM_MODULES > 1) ? $clog2(NUM_MODULES) : 1;
  localparam int AW          = MW + 3;
  localparam int DEPTH       = 2 ** AW;
  localparam int PANEL_W     = H_DISPLAYS * 8;
  localparam int PANEL_H     = V_DISPLAYS * 8;

  state_t state, state_next;

  logic [AW-1:0] sweep_addr;
  logic [7:0]    sweep_byte;
  logic [AW-1:0] pix_addr;
  logic [7:0]    pix_mask;
  logic          pix_color;
  logic [MW-1:0] mod_cnt;
  logic [2:0]    row_cnt;
  logic          out_valid;
  logic [3:0]    out_reg;
  logic [7:0]    out_data;
  logic          frame_end;
  logic          last;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic          req_fire;
  logic          word_fire;
  logic          pix_on_panel;
  logic [5:0]    pix_mod_wide;
  logic [MW-1:0] pix_mod;
  logic          mod_is_end;
  logic          next_mod_is_end;
  req_t          req_code;

  assign req_fire  = req.valid && req.ready;
  assign word_fire = word.valid && word.ready;
  assign req_code  = req_t'(req.req_type);

  assign pix_on_panel = !req.pos_x[15] && !req.pos_y[15]
                     && (req.pos_x[14:0] < 15'(PANEL_W))
                     && (req.pos_y[14:0] < 15'(PANEL_H));
  // module index in chain order: row of modules times the modules per row
  assign pix_mod_wide = 6'(req.pos_y[5:3] * 6'(H_DISPLAYS)) + 6'(req.pos_x[5:3]);
  assign pix_mod      = pix_mod_wide[MW-1:0];

  assign mod_is_end      = (mod_cnt == MW'(NUM_MODULES - 1));
  assign next_mod_is_end = (mod_cnt + MW'(1) == MW'(NUM_MODULES - 1));

  lmfs_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_SWEEP: begin
        if (sweep_addr == {AW{1'b1}}) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req.valid) begin
          case (req_code)
            REQ_PIXEL:     state_next = pix_on_panel ? ST_PIX_RD : ST_IDLE;
            REQ_FILL:      state_next = ST_SWEEP;
            REQ_REFRESH:   state_next = ST_SCAN_RD;
            REQ_INTENSITY: state_next = ST_BCAST;
            REQ_BROADCAST: state_next = ST_BCAST;
            default:       state_next = ST_IDLE;
          endcase
        end
      end
      ST_PIX_RD:  state_next = ST_PIX_WR;
      ST_PIX_WR:  state_next = ST_IDLE;
      ST_SCAN_RD: state_next = ST_SCAN_LD;
      ST_SCAN_LD: state_next = ST_SCAN_OUT;
      ST_SCAN_OUT: begin
        if (word.ready) state_next = last ? ST_IDLE : ST_SCAN_RD;
      end
      ST_BCAST: begin
        if (word.ready && last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs and ram control
  always_comb begin
    req.ready = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = sweep_addr;
    ram_wdata = sweep_byte;
    ram_raddr = {mod_cnt, row_cnt};
    case (state)
      ST_SWEEP: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        req.ready = 1'b1;
      end
      ST_PIX_RD: begin
        ram_raddr = pix_addr;
      end
      ST_PIX_WR: begin
        ram_we    = 1'b1;
        ram_waddr = pix_addr;
        ram_wdata = pix_color ? (ram_rdata | pix_mask) : (ram_rdata & ~pix_mask);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
      sweep_byte <= '0;
      out_valid  <= 1'b0;
      mod_cnt    <= '0;
      row_cnt    <= '0;
    end else begin
      case (state)
        ST_SWEEP: begin
          sweep_addr <= sweep_addr + AW'(1);
        end
        ST_IDLE: begin
          mod_cnt <= '0;
          row_cnt <= '0;
          if (req_fire) begin
            case (req_code)
              REQ_PIXEL: begin
                pix_addr  <= {pix_mod, req.pos_y[2:0]};
                pix_mask  <= 8'h80 >> req.pos_x[2:0];
                pix_color <= req.color;
              end
              REQ_FILL: begin
                sweep_addr <= '0;
                sweep_byte <= req.color ? BYTE_ONES : 8'h00;
              end
              REQ_INTENSITY: begin
                out_valid <= 1'b1;
                out_reg   <= REG_INTENSITY;
                out_data  <= (req.value > INTENSITY_MAX) ? INTENSITY_MAX : req.value;
                frame_end <= (NUM_MODULES == 1);
                last      <= (NUM_MODULES == 1);
              end
              REQ_BROADCAST: begin
                out_valid <= 1'b1;
                out_reg   <= req.reg_sel;
                out_data  <= req.value;
                frame_end <= (NUM_MODULES == 1);
                last      <= (NUM_MODULES == 1);
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN_LD: begin
          out_valid <= 1'b1;
          out_reg   <= 4'(row_cnt) + 4'd1;
          out_data  <= ram_rdata;
          frame_end <= mod_is_end;
          last      <= mod_is_end && (row_cnt == LAST_ROW);
        end
        ST_SCAN_OUT: begin
          if (word_fire) begin
            out_valid <= 1'b0;
            // chain order within a row, then the next row
            if (mod_is_end) begin
              mod_cnt <= '0;
              row_cnt <= row_cnt + 3'd1;
            end else begin
              mod_cnt <= mod_cnt + MW'(1);
            end
          end
        end
        ST_BCAST: begin
          if (word_fire) begin
            if (last) begin
              out_valid <= 1'b0;
            end else begin
              mod_cnt   <= mod_cnt + MW'(1);
              frame_end <= next_mod_is_end;
              last      <= next_mod_is_end;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign word.valid     = out_valid;
  assign word.out_reg   = out_reg;
  assign word.out_data  = out_data;
  assign word.frame_end = frame_end;
  assign word.last      = last;

endmodule

>>> design/lmfs_checker.sv
`timescale 1ns / 1ps

module lmfs_checker
  import lmfs_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic [2:0] req_type,
  input logic       word_valid,
  input logic       word_ready,
  input logic [3:0] out_reg,
  input logic [7:0] out_data,
  input logic       frame_end,
  input logic       last
);

  // a stalled beat keeps its payload
  a_word_hold: assert property (@(posedge clk) disable iff (rst)
    word_valid && !word_ready |=> word_valid && $stable(out_reg) && $stable(out_data)
      && $stable(frame_end) && $stable(last))
    else $error("stalled output beat changed");

  // no new request while words of the current one are pending
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    word_valid |-> !req_ready)
    else $error("request accepted while words pending");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (rst)
    word_valid && last |-> frame_end)
    else $error("last word without frame end");

  a_quiet_after_last: assert property (@(posedge clk) disable iff (rst)
    word_valid && word_ready && last |=> !word_valid)
    else $error("word after the last one of a request");

  a_pixel_silent: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_type == REQ_PIXEL || req_type == REQ_FILL)
      |=> !word_valid)
    else $error("pixel or fill request produced a word");

endmodule

bind led_matrix_frame_scanner lmfs_checker u_lmfs_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .req_type  (req.req_type),
  .word_valid(word.valid),
  .word_ready(word.ready),
  .out_reg   (word.out_reg),
  .out_data  (word.out_data),
  .frame_end (word.frame_end),
  .last      (word.last)
);

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import lmfs_pkg::*;

  localparam int H_DISP = 4;
  localparam int V_DISP = 2;
  localparam int MODULES = H_DISP * V_DISP;
  localparam int FB_BYTES = MODULES * 8;
  localparam int PANEL_W = H_DISP * 8;
  localparam int PANEL_H = V_DISP * 8;
  localparam int RANDOM_ITEMS = 425;
  localparam int SETTLE_CYCLES = 200;
  localparam longint CYCLE_LIMIT = 4_000_000;

  // codes outside the request set, taken and dropped by the block
  localparam logic [2:0] REQ_SPARE_A = 3'd5;
  localparam logic [2:0] REQ_SPARE_B = 3'd6;
  localparam logic [2:0] REQ_SPARE_C = 3'd7;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               color;
    logic [3:0]         sel;
    logic [7:0]         level;
  } request_t;

  typedef struct packed {
    logic [3:0] addr;
    logic [7:0] data;
    logic       frame_end;
    logic       is_last;
  } word_t;

  typedef struct packed {
    request_t   rq;
    logic       typed;
    logic [7:0] want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;

  lmfs_req_if  req_ch ();
  lmfs_word_if word_ch ();

  led_matrix_frame_scanner #(
    .H_DISPLAYS(H_DISP),
    .V_DISPLAYS(V_DISP)
  ) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .word(word_ch)
  );

  logic [7:0] shadow_fb [FB_BYTES];
  word_t      words_due [$];
  int         errors;
  longint     cycles;
  bit         src_calm;
  bit         snk_calm;
  int         stall_left;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit on_panel(logic signed [15:0] x, logic signed [15:0] y);
    int px;
    int py;
    px = x;
    py = y;
    return px >= 0 && py >= 0 && px < PANEL_W && py < PANEL_H;
  endfunction

  function automatic void queue_frame(logic [3:0] addr, logic [7:0] data);
    word_t w;
    for (int m = 0; m < MODULES; m++) begin
      w.addr = addr;
      w.data = data;
      w.frame_end = (m == MODULES - 1);
      w.is_last = w.frame_end;
      words_due.push_back(w);
    end
  endfunction

  // one word per module per row, chain order, chip select released after each row
  function automatic void queue_scan(logic uniform, logic [7:0] level_byte);
    word_t w;
    for (int r = 1; r <= ROWS; r++) begin
      for (int m = 0; m < MODULES; m++) begin
        w.addr = 4'(r);
        w.data = uniform ? level_byte : shadow_fb[m * 8 + r - 1];
        w.frame_end = (m == MODULES - 1);
        w.is_last = w.frame_end && (r == ROWS);
        words_due.push_back(w);
      end
    end
  endfunction

  function automatic void apply_request(request_t rq);
    int px;
    int py;
    int idx;
    px = rq.x;
    py = rq.y;
    case (rq.kind)
      REQ_PIXEL: begin
        if (on_panel(rq.x, rq.y)) begin
          idx = ((py / 8) * H_DISP + px / 8) * 8 + py % 8;
          // bit 7 is the leftmost column
          shadow_fb[idx][7 - px % 8] = rq.color;
        end
      end
      REQ_FILL: begin
        for (int i = 0; i < FB_BYTES; i++) shadow_fb[i] = rq.color ? BYTE_ONES : 8'h00;
      end
      REQ_REFRESH: queue_scan(1'b0, 8'h00);
      REQ_INTENSITY: begin
        queue_frame(REG_INTENSITY, rq.level > INTENSITY_MAX ? INTENSITY_MAX : rq.level);
      end
      REQ_BROADCAST: queue_frame(rq.sel, rq.level);
      default: ;
    endcase
  endfunction

  function automatic void queue_typed(request_t rq, logic [7:0] want);
    if (rq.kind == REQ_REFRESH) queue_scan(1'b1, want);
    else queue_frame(rq.kind == REQ_INTENSITY ? REG_INTENSITY : rq.sel, want);
  endfunction

  function automatic int idle_len(bit calm);
    int p;
    if (calm) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic plan_row_t plan_entry(logic [2:0] kind, int x, int y, logic color,
                                           logic [3:0] sel, logic [7:0] level,
                                           logic typed, logic [7:0] want);
    plan_row_t e;
    e.rq.kind = kind;
    e.rq.x = 16'(x);
    e.rq.y = 16'(y);
    e.rq.color = color;
    e.rq.sel = sel;
    e.rq.level = level;
    e.typed = typed;
    e.want = want;
    return e;
  endfunction

  function automatic request_t random_request();
    request_t rq;
    int p;
    rq.x = 16'($urandom);
    rq.y = 16'($urandom);
    rq.color = 1'($urandom);
    rq.sel = 4'($urandom);
    rq.level = 8'($urandom);
    p = $urandom_range(0, 99);
    if (p < 50) begin
      rq.kind = REQ_PIXEL;
      rq.x = 16'($urandom_range(0, PANEL_W - 1));
      rq.y = 16'($urandom_range(0, PANEL_H - 1));
    end else if (p < 58) begin
      rq.kind = REQ_PIXEL;
      // mostly just past an edge, otherwise anywhere off the panel
      case ($urandom_range(0, 3))
        0: rq.x = 16'(-1 - int'($urandom_range(0, 7)));
        1: rq.x = 16'(PANEL_W + $urandom_range(0, 7));
        2: rq.y = 16'(PANEL_H + $urandom_range(0, 7));
        default: ;
      endcase
      while (on_panel(rq.x, rq.y)) rq.x = 16'($urandom);
    end else if (p < 62) begin
      rq.kind = REQ_FILL;
    end else if (p < 72) begin
      rq.kind = REQ_REFRESH;
    end else if (p < 80) begin
      rq.kind = REQ_INTENSITY;
      if ($urandom_range(0, 1)) rq.level = 8'($urandom_range(0, 20));
    end else if (p < 93) begin
      rq.kind = REQ_BROADCAST;
    end else begin
      rq.kind = REQ_SPARE_A + 3'($urandom_range(0, 2));
    end
    return rq;
  endfunction

  task automatic send(request_t rq, logic typed, logic [7:0] want);
    int gap;
    req_ch.valid <= 1'b1;
    req_ch.req_type <= rq.kind;
    req_ch.pos_x <= rq.x;
    req_ch.pos_y <= rq.y;
    req_ch.color <= rq.color;
    req_ch.reg_sel <= rq.sel;
    req_ch.value <= rq.level;
    do @(posedge clk); while (!req_ch.ready);
    if (typed) queue_typed(rq, want);
    else apply_request(rq);
    gap = idle_len(src_calm);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic hold_until_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (words_due.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles % 300 == 0) begin
      src_calm <= ($urandom_range(0, 3) == 0);
      snk_calm <= ($urandom_range(0, 3) == 0);
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL led_matrix_frame_scanner");
      $finish;
    end
  end

  always @(posedge clk) begin : sink_stall
    int n;
    if (stall_left > 0) begin
      word_ch.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      n = idle_len(snk_calm);
      word_ch.ready <= (n == 0);
      if (n > 0) stall_left = n - 1;
    end
  end

  always @(posedge clk) begin : word_check
    word_t got;
    word_t exp_w;
    if (!rst && word_ch.valid && word_ch.ready) begin
      got = {word_ch.out_reg, word_ch.out_data, word_ch.frame_end, word_ch.last};
      if (words_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected beat: reg %0d data %02h frame_end %0b last %0b",
                   got.addr, got.data, got.frame_end, got.is_last);
      end else begin
        exp_w = words_due.pop_front();
        if (got !== exp_w) begin
          errors++;
          if (errors <= 10)
            $display("beat mismatch: reg %0d/%0d data %02h/%02h frame_end %0b/%0b last %0b/%0b",
                     exp_w.addr, got.addr, exp_w.data, got.data,
                     exp_w.frame_end, got.frame_end, exp_w.is_last, got.is_last);
        end
      end
    end
  end

  initial begin
    plan_row_t plan [];
    request_t  rq;
    int        done_items;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_PIXEL;
    req_ch.pos_x = '0;
    req_ch.pos_y = '0;
    req_ch.color = 1'b0;
    req_ch.reg_sel = '0;
    req_ch.value = '0;
    for (int i = 0; i < FB_BYTES; i++) shadow_fb[i] = 8'h00;

    plan = '{
      plan_entry(REQ_REFRESH,   0, 0, 1'b0, 4'd0,  8'd0,   1'b1, 8'h00),
      plan_entry(REQ_INTENSITY, 0, 0, 1'b0, 4'd0,  8'd255, 1'b1, 8'd15),
      plan_entry(REQ_INTENSITY, 0, 0, 1'b0, 4'd0,  8'd0,   1'b1, 8'd0),
      plan_entry(REQ_INTENSITY, 0, 0, 1'b0, 4'd0,  8'd15,  1'b1, 8'd15),
      plan_entry(REQ_INTENSITY, 0, 0, 1'b0, 4'd0,  8'd16,  1'b1, 8'd15),
      plan_entry(REQ_BROADCAST, 0, 0, 1'b0, 4'd15, 8'd255, 1'b1, 8'd255),
      plan_entry(REQ_BROADCAST, 0, 0, 1'b0, 4'd0,  8'd0,   1'b1, 8'd0),
      plan_entry(REQ_FILL,      0, 0, 1'b1, 4'd0,  8'd0,   1'b0, 8'h00),
      plan_entry(REQ_REFRESH,   0, 0, 1'b0, 4'd0,  8'd0,   1'b1, 8'hFF),
      plan_entry(REQ_PIXEL,     0, 0, 1'b0, 4'd0,  8'd0,   1'b0, 8'h00),
      plan_entry(REQ_PIXEL,    31, 15, 1'b0, 4'd0, 8'd0,   1'b0, 8'h00),
      // just off each edge, then the far corners of the coordinate range
      plan_entry(REQ_PIXEL,    32, 0, 1'b0, 4'd0,  8'd0,   1'b0, 8'h00),
      plan_entry(REQ_PIXEL,     0, 16, 1'b0, 4'd0, 8'd0,   1'b0, 8'h00),
      plan_entry(REQ_PIXEL,    -1, 0, 1'b0, 4'd0,  8'd0,   1'b0, 8'h00),
      plan_entry(REQ_PIXEL,     0, -1, 1'b0, 4'd0, 8'd0,   1'b0, 8'h00),
      plan_entry(REQ_PIXEL, -32768, 32767, 1'b0, 4'd0, 8'd0, 1'b0, 8'h00),
      plan_entry(REQ_PIXEL, 32767, -32768, 1'b0, 4'd0, 8'd0, 1'b0, 8'h00),
      plan_entry(REQ_REFRESH,   0, 0, 1'b0, 4'd0,  8'd0,   1'b0, 8'h00),
      plan_entry(REQ_FILL,      0, 0, 1'b0, 4'd0,  8'd0,   1'b0, 8'h00),
      plan_entry(REQ_PIXEL,     7, 8, 1'b1, 4'd0,  8'd0,   1'b0, 8'h00),
      plan_entry(REQ_PIXEL,     8, 7, 1'b1, 4'd0,  8'd0,   1'b0, 8'h00),
      plan_entry(REQ_SPARE_A,   3, 3, 1'b1, 4'd3,  8'd3,   1'b0, 8'h00),
      plan_entry(REQ_SPARE_B,   0, 0, 1'b0, 4'd0,  8'd0,   1'b0, 8'h00),
      plan_entry(REQ_SPARE_C,  -1, -1, 1'b1, 4'd15, 8'd255, 1'b0, 8'h00),
      plan_entry(REQ_REFRESH,   0, 0, 1'b0, 4'd0,  8'd0,   1'b0, 8'h00)
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send(plan[i].rq, plan[i].typed, plan[i].want);
    hold_until_drained();

    done_items = 0;
    while (done_items < RANDOM_ITEMS) begin
      rq = random_request();
      done_items++;
      send(rq, 1'b0, 8'h00);
      if (done_items == RANDOM_ITEMS / 2 || $urandom_range(0, 99) == 0) hold_until_drained();
    end

    hold_until_drained();
    // a fill sweep produces no beats and may still be running
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && words_due.size() == 0) $display("PASS led_matrix_frame_scanner");
    else $display("FAIL led_matrix_frame_scanner");
    $finish;
  end

endmodule

>>> sim.f
design/lmfs_pkg.sv
design/lmfs_if.sv
design/lmfs_ram.sv
design/led_matrix_frame_scanner.sv
design/lmfs_checker.sv
verif/tb.sv
